### rtl/core/cdq_pkg.sv
// Shared types and codes for the coordinate deque.
// No dependencies; imported by cdq_ctrl and coordinate_deque_with_search.
package cdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_INDEX = 3'd4,
        OP_CONTAINS   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        status_t status;
        logic    found;
    } resp_flags_t;

endpackage

### rtl/core/cdq_mem.sv
// Entry storage for the coordinate deque: one write port, one read port,
// read data registered. No dependencies.
module cdq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/cdq_ctrl.sv
// Request sequencer for the coordinate deque: ring pointers, count, search scan.
// Depends on cdq_pkg; drives the ports of cdq_mem.
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int COORD_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [2:0]                       req_op,
    input  logic [2*COORD_BITS-1:0]          req_pair,
    input  logic [$clog2(DEPTH)-1:0]         req_index,
    output logic                             mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
    output logic [2*COORD_BITS-1:0]          mem_wr_data,
    output logic                             mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
    input  logic [2*COORD_BITS-1:0]          mem_rd_data,
    output logic                             res_valid,
    input  logic                             res_take,
    output resp_flags_t                      res_flags,
    output logic [2*COORD_BITS-1:0]          res_item,
    output logic [$clog2(DEPTH+1)-1:0]       res_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = 2 * COORD_BITS;
    localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [PW-1:0]     pair_reg, pair_next;
    resp_flags_t       flags_reg, flags_next;
    logic [PW-1:0]     item_reg, item_next;
    logic [AW-1:0]     scan_pos_reg, scan_pos_next;
    logic [AW-1:0]     scan_slot_reg, scan_slot_next;

    logic              full, empty;
    logic [AW-1:0]     front_dec, front_inc, back_slot, last_slot, idx_slot, scan_slot_inc;
    logic [CW-1:0]     idx_ext;

    // ring position -> slot; sum stays below twice the depth
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(pos);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);
    assign idx_ext   = CW'(req_index);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);
    assign back_slot = slot_of(front_reg, count_reg);
    assign last_slot = slot_of(front_reg, count_reg - CW'(1));
    assign idx_slot  = slot_of(front_reg, idx_ext);
    assign scan_slot_inc = (scan_slot_reg == LAST_SLOT) ? '0 : scan_slot_reg + AW'(1);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        pair_next      = pair_reg;
        flags_next     = flags_reg;
        item_next      = item_reg;
        scan_pos_next  = scan_pos_reg;
        scan_slot_next = scan_slot_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = front_dec;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pair_next  = req_pair;
                    flags_next = '{status: ST_OK, found: 1'b0};
                    item_next  = '0;
                    state_next = S_RESP;
                    case (op_t'(req_op))
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                flags_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = front_dec;
                                front_next  = front_dec;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                flags_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = back_slot;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                flags_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = front_reg;
                                front_next  = front_inc;
                                count_next  = count_reg - CW'(1);
                                state_next  = S_READ;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                flags_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = last_slot;
                                count_next  = count_reg - CW'(1);
                                state_next  = S_READ;
                            end
                        end
                        OP_READ_INDEX:
                        begin
                            if (idx_ext >= count_reg)
                            begin
                                flags_next.status = ST_RANGE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = idx_slot;
                                state_next  = S_READ;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            if (!empty)
                            begin
                                mem_rd_en      = 1'b1;
                                mem_rd_addr    = front_reg;
                                scan_pos_next  = '0;
                                scan_slot_next = front_inc;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                item_next  = mem_rd_data;
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                // mem_rd_data holds the entry at scan_pos_reg
                if (mem_rd_data == pair_reg)
                begin
                    flags_next.found = 1'b1;
                    state_next       = S_RESP;
                end
                else if (CW'(scan_pos_reg) + CW'(1) == count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = scan_slot_reg;
                    scan_slot_next = scan_slot_inc;
                    scan_pos_next  = scan_pos_reg + AW'(1);
                end
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg      <= pair_next;
        flags_reg     <= flags_next;
        item_reg      <= item_next;
        scan_pos_reg  <= scan_pos_next;
        scan_slot_reg <= scan_slot_next;
    end

    // pushes write in the accepting cycle, straight from the request beat
    assign mem_wr_data = req_pair;
    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_RESP);
    assign res_flags   = flags_reg;
    assign res_item    = item_reg;
    assign res_count   = count_reg;

endmodule

### rtl/core/coordinate_deque_with_search.sv
// Coordinate deque with search: bounded double-ended queue of (x,y) pairs.
// Input channel (in_valid/in_stall) carries one request per beat: operation,
// coord_x, coord_y, index. Output channel (out_valid/out_stall) returns one
// result beat per request: status, found, item_x, item_y, count.
// Requests are handled one at a time by a sequencer around a single-port-read
// entry memory with registered read data; each request steps through states:
//   push, failed pop/read, unused codes : S_IDLE, S_RESP
//   pop front/back, read index          : S_IDLE, S_READ, S_RESP
//   contains                            : S_IDLE, S_SCAN (n compares), S_RESP
//                                         (n <= count, one memory read a cycle)
// The memory read port sets the search rate.
// A result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, the sequencer holds its next result until the
// output register frees up, and in_stall stays high meanwhile.
// Reset empties the queue at once (front and count cleared); entry storage
// needs no clearing since only stored slots are ever read.
// Depends on cdq_pkg, cdq_ctrl, cdq_mem.
module coordinate_deque_with_search
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int COORD_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     operation,
    input  logic [COORD_BITS-1:0]          coord_x,
    input  logic [COORD_BITS-1:0]          coord_y,
    input  logic [$clog2(DEPTH)-1:0]       index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic                           found,
    output logic [COORD_BITS-1:0]          item_x,
    output logic [COORD_BITS-1:0]          item_y,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = 2 * COORD_BITS;

    logic              req_ready;
    logic              mem_wr_en, mem_rd_en;
    logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
    logic [PW-1:0]     mem_wr_data, mem_rd_data;
    logic              res_valid, res_take, out_free;
    resp_flags_t       res_flags;
    logic [PW-1:0]     res_item;
    logic [CW-1:0]     res_count;

    logic              out_valid_reg;
    resp_flags_t       flags_reg;
    logic [PW-1:0]     item_reg;
    logic [CW-1:0]     count_reg;

    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (in_valid),
        .req_ready   (req_ready),
        .req_op      (operation),
        .req_pair    ({coord_x, coord_y}),
        .req_index   (index),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_flags   (res_flags),
        .res_item    (res_item),
        .res_count   (res_count)
    );

    cdq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (PW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_stall = !req_ready;
    assign out_free = !out_valid_reg || !out_stall;
    assign res_take = res_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            flags_reg <= res_flags;
            item_reg  <= res_item;
            count_reg <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = flags_reg.status;
    assign found     = flags_reg.found;
    assign item_x    = item_reg[PW-1:COORD_BITS];
    assign item_y    = item_reg[COORD_BITS-1:0];
    assign count     = count_reg;

    // count never runs past the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CW'(DEPTH)))
        else $error("count beyond depth");

    // a hit only comes from a search, which carries no item and no error
    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ST_OK && item_x == '0 && item_y == '0))
        else $error("found with item or error");

    // refused requests return no item
    a_error_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (item_x == '0 && item_y == '0 && !found))
        else $error("error status with payload");

    // one request at a time: the beat after a request is always stalled
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while busy");

endmodule

### tb/sv/cdq_tb_pkg.sv
// Scoreboard for the coordinate deque: a ring-buffer predictor plus the list of awaited results.
// Depends on cdq_pkg for the operation and status codes.
package cdq_tb_pkg;
    import cdq_pkg::*;

    localparam int unsigned SLOTS = 64;
    // Codes outside the operation set; the block answers them with count only
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int unsigned PRINT_CAP = 40;

    typedef struct packed {
        status_t    status;
        logic       found;
        logic [7:0] x;
        logic [7:0] y;
        logic [6:0] used;
    } deque_reply_t;

    class deque_scoreboard;
        logic [15:0]  slots [SLOTS];
        logic [5:0]   head;
        logic [6:0]   used;
        deque_reply_t awaited [$];
        int unsigned  errors;
        int unsigned  results_seen;
        int unsigned  full_hits;
        int unsigned  empty_hits;
        int unsigned  range_hits;
        int unsigned  found_hits;

        function new();
            head = '0;
            used = '0;
            errors = 0;
            results_seen = 0;
            full_hits = 0;
            empty_hits = 0;
            range_hits = 0;
            found_hits = 0;
        endfunction

        function logic [15:0] pair_at(int unsigned pos);
            logic [5:0] slot;
            slot = head + pos[5:0];
            return slots[slot];
        endfunction

        // Advance the deque by one accepted request and queue its answer
        function void note_request(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                   logic [5:0] idx);
            deque_reply_t want;
            logic [15:0]  pair;
            want.status = ST_OK;
            want.found  = 1'b0;
            want.x      = '0;
            want.y      = '0;
            pair = {x, y};
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                    if (used == 7'(SLOTS)) begin
                        want.status = ST_FULL;
                    end
                    else if (op == OP_PUSH_FRONT) begin
                        head = head - 6'd1;
                        slots[head] = pair;
                        used = used + 7'd1;
                    end
                    else begin
                        slots[head + used[5:0]] = pair;
                        used = used + 7'd1;
                    end
                OP_POP_FRONT, OP_POP_BACK:
                    if (used == '0) begin
                        want.status = ST_EMPTY;
                    end
                    else if (op == OP_POP_FRONT) begin
                        {want.x, want.y} = slots[head];
                        head = head + 6'd1;
                        used = used - 7'd1;
                    end
                    else begin
                        {want.x, want.y} = pair_at(used - 7'd1);
                        used = used - 7'd1;
                    end
                OP_READ_INDEX:
                    if ({1'b0, idx} >= used)
                        want.status = ST_RANGE;
                    else
                        {want.x, want.y} = pair_at(idx);
                OP_CONTAINS:
                    for (int unsigned k = 0; k < used; k++) begin
                        if (pair_at(k) == pair)
                            want.found = 1'b1;
                    end
                default: ;
            endcase
            want.used = used;
            case (want.status)
                ST_FULL:  full_hits++;
                ST_EMPTY: empty_hits++;
                ST_RANGE: range_hits++;
                default:  ;
            endcase
            if (want.found)
                found_hits++;
            awaited.push_back(want);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                         results_seen, what, got, want);
        endtask

        task check_result(logic [1:0] st, logic fnd, logic [7:0] x, logic [7:0] y,
                          logic [6:0] cnt);
            deque_reply_t want;
            results_seen++;
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing awaited", {st, fnd, cnt}, '0);
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
                report_mismatch("status", st, want.status);
            if (fnd !== want.found)
                report_mismatch("found", fnd, want.found);
            if (x !== want.x)
                report_mismatch("item_x", x, want.x);
            if (y !== want.y)
                report_mismatch("item_y", y, want.y);
            if (cnt !== want.used)
                report_mismatch("count", cnt, want.used);
        endtask
    endclass

endpackage

### tb/sv/testbench.sv
// Top-level bench for coordinate_deque_with_search: drives requests, stalls results, checks beats.
// Depends on cdq_pkg, cdq_tb_pkg and the deque RTL.
module testbench;
    import cdq_pkg::*;
    import cdq_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet-stretch limit, set above the result hold plus one full-depth search
    localparam int unsigned QUIET_LIMIT    = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PHASE_REQUESTS = 400;
    localparam int unsigned DRAIN_CYCLES   = 100;

    typedef enum logic [1:0] {
        FILL_UP,
        DRAIN_DOWN,
        MIXED
    } burst_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] operation = '0;
    logic [7:0] coord_x = '0;
    logic [7:0] coord_y = '0;
    logic [5:0] index = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic       found;
    logic [7:0] item_x;
    logic [7:0] item_y;
    logic [6:0] count;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned requests_done = 0;
    int unsigned quiet_cycles = 0;

    deque_scoreboard sb = new();

    coordinate_deque_with_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .index     (index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found     (found),
        .item_x    (item_x),
        .item_y    (item_y),
        .count     (count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: random stalls, or a long hold when one is requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, found, item_x, item_y, count);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat on either channel for %0d cycles", QUIET_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after a falling edge
    task automatic send_request(logic [2:0] op, logic [7:0] x, logic [7:0] y, logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        coord_x   = x;
        coord_y   = y;
        index     = idx;
        do @(posedge clk); while (in_stall);
        sb.note_request(op, x, y, idx);
        if (op != OP_SPARE_6 && op != OP_SPARE_7)
            requests_done++;
        @(negedge clk);
    endtask

    // Small pool so searches and duplicates hit often, plus the extremes
    function automatic logic [7:0] pick_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25)
            return 8'($urandom_range(3));
        if (r < 35)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [5:0] pick_index();
        if (sb.used != 0 && $urandom_range(99) < 80)
            return 6'($urandom_range(sb.used - 1));
        return 6'($urandom_range(63));
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    task automatic send_random(burst_t mode);
        int unsigned r;
        logic [2:0]  op;
        logic [7:0]  x;
        logic [7:0]  y;
        r = $urandom_range(99);
        if ($urandom_range(99) < 2)
            op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
        else if (mode == FILL_UP)
            op = r < 70 ? pick_push() : r < 80 ? OP_READ_INDEX : r < 90 ? OP_CONTAINS : pick_pop();
        else if (mode == DRAIN_DOWN)
            op = r < 60 ? pick_pop() : r < 75 ? OP_READ_INDEX : r < 90 ? OP_CONTAINS : pick_push();
        else
            op = 3'($urandom_range(5));
        x = pick_coord();
        y = pick_coord();
        if (op == OP_CONTAINS && sb.used != 0 && $urandom_range(1))
            {x, y} = sb.pair_at($urandom_range(sb.used - 1));
        send_request(op, x, y, pick_index());
    endtask

    // Fill to the brim, push into a full deque, probe both ends, then drain past empty
    task automatic run_full_cycle();
        logic [15:0] tail_pair;
        while (sb.used < 7'(SLOTS))
            send_request(pick_push(), pick_coord(), pick_coord(), pick_index());
        repeat (3)
            send_request(pick_push(), pick_coord(), pick_coord(), pick_index());
        send_request(OP_READ_INDEX, 8'h00, 8'h00, 6'd63);
        send_request(OP_READ_INDEX, 8'hFF, 8'hFF, 6'd0);
        tail_pair = sb.pair_at(SLOTS - 1);
        send_request(OP_CONTAINS, tail_pair[15:8], tail_pair[7:0], 6'd0);
        while (sb.used > 0)
            send_request(pick_pop(), pick_coord(), pick_coord(), pick_index());
        repeat (2)
            send_request(pick_pop(), pick_coord(), pick_coord(), pick_index());
    endtask

    task automatic run_directed();
        send_request(OP_POP_FRONT, 8'h00, 8'h00, 6'd0);
        send_request(OP_POP_BACK, 8'hFF, 8'hFF, 6'd63);
        send_request(OP_READ_INDEX, 8'h00, 8'h00, 6'd0);
        send_request(OP_CONTAINS, 8'h00, 8'h00, 6'd0);
        send_request(OP_SPARE_6, 8'hFF, 8'hFF, 6'd63);
        send_request(OP_SPARE_7, 8'h00, 8'h00, 6'd0);
        send_request(OP_PUSH_BACK, 8'h00, 8'h00, 6'd0);
        send_request(OP_PUSH_BACK, 8'hFF, 8'hFF, 6'd63);
        send_request(OP_PUSH_FRONT, 8'hAA, 8'h55, 6'd0);
        send_request(OP_PUSH_FRONT, 8'h55, 8'hAA, 6'd0);
        send_request(OP_READ_INDEX, 8'h00, 8'h00, 6'd0);
        send_request(OP_READ_INDEX, 8'h00, 8'h00, 6'd3);
        send_request(OP_READ_INDEX, 8'h00, 8'h00, 6'd4);
        send_request(OP_READ_INDEX, 8'h00, 8'h00, 6'd63);
        send_request(OP_CONTAINS, 8'hFF, 8'hFF, 6'd0);
        send_request(OP_CONTAINS, 8'hFF, 8'h00, 6'd0);
        send_request(OP_CONTAINS, 8'h00, 8'h00, 6'd0);
        send_request(OP_POP_FRONT, 8'h00, 8'h00, 6'd0);
        send_request(OP_POP_BACK, 8'h00, 8'h00, 6'd0);
        send_request(OP_SPARE_7, 8'hFF, 8'hFF, 6'd63);
        send_request(OP_POP_BACK, 8'h00, 8'h00, 6'd0);
        send_request(OP_POP_FRONT, 8'h00, 8'h00, 6'd0);
        send_request(OP_POP_FRONT, 8'h00, 8'h00, 6'd0);
    endtask

    initial
    begin
        int unsigned phase_start;
        int unsigned idle_mix [5][2];
        idle_mix = '{'{0, 0}, '{0, 0}, '{77, 0}, '{0, 77}, '{30, 30}};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (int p = 0; p < 5; p++)
        begin
            send_idle_pct = idle_mix[p][0];
            stall_pct     = idle_mix[p][1];
            if (p == 1)
            begin
                // Results held back while requests keep coming: input must back up
                hold_request = HOLD_CYCLES;
                repeat (80)
                    send_random(FILL_UP);
            end
            else
            begin
                phase_start = requests_done;
                run_full_cycle();
                while (requests_done - phase_start < PHASE_REQUESTS)
                begin
                    burst_t mode;
                    mode = burst_t'($urandom_range(2));
                    repeat ($urandom_range(20, 90))
                        send_random(mode);
                end
            end
        end

        in_valid = 1'b0;
        stall_pct = 0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests, %0d result beats compared, under four idle/stall mixes",
                 requests_done, sb.results_seen);
        $display("plus a long result hold; full %0d, empty %0d, past-end %0d, search hits %0d",
                 sb.full_hits, sb.empty_hits, sb.range_hits, sb.found_hits);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
